>>> sv/ladq_pkg.sv
// Package for the linear array deque: request and status codes,
// controller states and the command/status structs between controller and datapath.
// No dependencies.
package ladq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int DATA_W    = 32;
  localparam int REQ_W     = 3;
  localparam int STAT_W    = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_BACK  = 3'd0,
    REQ_PUSH_FRONT = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_BACK   = 3'd3,
    REQ_QUERY      = 3'd4
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_LOAD
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;  // latch the request beat
    logic exec;     // update indices, write slot
    logic read;     // read front and back slots
    logic load;     // fill the result register
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_busy; // result register holds a beat that is not taken this cycle
  } dp_stat_t;

endpackage

>>> sv/ladq_in_if.sv
// Request channel interface: valid/ready handshake with request payload.
// Depends on ladq_pkg.
interface ladq_in_if;
  import ladq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [REQ_W-1:0]         req_type;
  logic signed [DATA_W-1:0] data;

  modport source (output valid, output req_type, output data, input ready);
  modport sink   (input valid, input req_type, input data, output ready);
endinterface

>>> sv/ladq_out_if.sv
// Result channel interface: valid/ready handshake with result payload.
// Depends on ladq_pkg.
interface ladq_out_if #(
  parameter int COUNT_W = $clog2(ladq_pkg::DEPTH_DEF + 1)
);
  import ladq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [STAT_W-1:0]        status;
  logic [COUNT_W-1:0]       count;
  logic signed [DATA_W-1:0] front_value;
  logic signed [DATA_W-1:0] back_value;

  modport source (output valid, output status, output count, output front_value,
                  output back_value, input ready);
  modport sink   (input valid, input status, input count, input front_value,
                  input back_value, output ready);
endinterface

>>> sv/linear_array_deque.sv
// Linear array deque, top level: joins the controller and datapath to the channels.
// Depends on ladq_pkg, ladq_in_if, ladq_out_if, ladq_ctrl, ladq_dp.
//
//   channel   dir  modport  payload                                   beat when
//   in_chan   in   sink     req_type[2:0], data[31:0] signed          valid & ready
//   out_chan  out  source   status[1:0], count, front/back_value      valid & ready
//
// Steps per request: accept, index update with slot write, registered read of front
//   and back slots, result load. A new request is accepted only after the load.
//   The single-port slot write comes before the registered read of front and back.
// The result register decouples the sides; a stalled out_chan holds the controller
//   in its load step, and in_chan.ready stays low until the result is loaded.
// Reset: rst_n (synchronous, active low) clears the indices, sets the empty flag, resets the
//   controller and clears the result valid. The slot memory is not cleared: empty reads -1.
module linear_array_deque #(
  parameter int DEPTH = ladq_pkg::DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  ladq_in_if.sink           in_chan,
  ladq_out_if.source        out_chan
);
  import ladq_pkg::*;

  // count must hold DEPTH itself
  localparam int COUNT_W = $clog2(DEPTH + 1);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  ladq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ladq_dp #(
    .DEPTH   (DEPTH),
    .COUNT_W (COUNT_W)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_req     (in_chan.req_type),
    .in_data    (in_chan.data),
    .out_ready  (out_chan.ready),
    .out_valid  (out_chan.valid),
    .out_status (out_chan.status),
    .out_count  (out_chan.count),
    .out_front  (out_chan.front_value),
    .out_back   (out_chan.back_value)
  );

endmodule

>>> sv/ladq_ctrl.sv
// Deque controller: sequences accept, update, slot read and result load.
// Depends on ladq_pkg.
module ladq_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ladq_pkg::dp_stat_t   stat,
  output ladq_pkg::ctrl_cmd_t  cmd
);
  import ladq_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_READ;
      end
      S_READ: begin
        cmd.read  = 1'b1;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        // hold until the result register frees up
        if (!stat.out_busy) begin
          cmd.load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

>>> sv/ladq_dp.sv
// Deque datapath: head/tail indices, empty flag, slot memory and result register.
// Depends on ladq_pkg; driven by ladq_ctrl commands.
module ladq_dp #(
  parameter int DEPTH   = ladq_pkg::DEPTH_DEF,
  parameter int COUNT_W = $clog2(DEPTH + 1)
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  ladq_pkg::ctrl_cmd_t                cmd,
  output ladq_pkg::dp_stat_t                 stat,
  input  logic [ladq_pkg::REQ_W-1:0]         in_req,
  input  logic signed [ladq_pkg::DATA_W-1:0] in_data,
  input  logic                               out_ready,
  output logic                               out_valid,
  output logic [ladq_pkg::STAT_W-1:0]        out_status,
  output logic [COUNT_W-1:0]                 out_count,
  output logic signed [ladq_pkg::DATA_W-1:0] out_front,
  output logic signed [ladq_pkg::DATA_W-1:0] out_back
);
  import ladq_pkg::*;

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

  // latched request
  logic [REQ_W-1:0]  req_r;
  logic [DATA_W-1:0] data_r;

  // deque state
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [IDX_W-1:0] tail_r, tail_nxt;
  logic             empty_r, empty_nxt;
  status_t          st_r, st_nxt;

  // slot memory
  logic [DATA_W-1:0] mem_r [DEPTH];
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [DATA_W-1:0] rd_front_r, rd_back_r;

  // result register
  logic                     out_valid_r;
  status_t                  out_st_r;
  logic [COUNT_W-1:0]       out_count_r, count_nxt;
  logic [DATA_W-1:0]        out_front_r, out_back_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r  <= in_req;
      data_r <= in_data;
    end
  end

  // request decode and index update
  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    empty_nxt = empty_r;
    st_nxt    = ST_OK;
    wr_en     = 1'b0;
    wr_addr   = '0;
    unique case (req_r) inside
      REQ_PUSH_BACK, REQ_PUSH_FRONT: begin
        if (empty_r) begin
          head_nxt  = '0;
          tail_nxt  = '0;
          empty_nxt = 1'b0;
          wr_en     = 1'b1;
          wr_addr   = '0;
        end else if (req_r == REQ_PUSH_BACK) begin
          if (tail_r == LAST_IDX) begin
            st_nxt = ST_OVERFLOW;
          end else begin
            tail_nxt = tail_r + 1'b1;
            wr_en    = 1'b1;
            wr_addr  = tail_r + 1'b1;
          end
        end else begin
          if (head_r == '0) begin
            st_nxt = ST_OVERFLOW;
          end else begin
            head_nxt = head_r - 1'b1;
            wr_en    = 1'b1;
            wr_addr  = head_r - 1'b1;
          end
        end
      end
      REQ_POP_FRONT, REQ_POP_BACK: begin
        if (empty_r) begin
          st_nxt = ST_UNDERFLOW;
        end else if (head_r == tail_r) begin
          empty_nxt = 1'b1;
          head_nxt  = '0;
          tail_nxt  = '0;
        end else if (req_r == REQ_POP_FRONT) begin
          head_nxt = head_r + 1'b1;
        end else begin
          tail_nxt = tail_r - 1'b1;
        end
      end
      default: ; // query and unused codes
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      empty_r <= 1'b1;
    end else if (cmd.exec) begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      empty_r <= empty_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en) begin
      mem_r[wr_addr] <= data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      rd_front_r <= mem_r[head_r];
      rd_back_r  <= mem_r[tail_r];
    end
  end

  assign count_nxt = empty_r ? '0
                             : COUNT_W'(tail_r) - COUNT_W'(head_r) + COUNT_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_st_r    <= st_r;
      out_count_r <= count_nxt;
      out_front_r <= empty_r ? '1 : rd_front_r;
      out_back_r  <= empty_r ? '1 : rd_back_r;
    end
  end

  assign stat.out_busy = out_valid_r && !out_ready;
  assign out_valid     = out_valid_r;
  assign out_status    = out_st_r;
  assign out_count     = out_count_r;
  assign out_front     = out_front_r;
  assign out_back      = out_back_r;

`ifndef SYNTHESIS
  a_empty_idx: assert property (@(posedge clk) disable iff (!rst_n)
    empty_r |-> (head_r == '0 && tail_r == '0))
    else $error("empty deque with non-zero indices");

  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    !empty_r |-> (head_r <= tail_r))
    else $error("head index past tail index");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> !(out_valid_r && !out_ready))
    else $error("result register overwritten before its beat was taken");

  a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.exec |=> ($stable(head_r) && $stable(tail_r) && $stable(empty_r)))
    else $error("deque state moved outside the update cycle");
`endif

endmodule

>>> verif/tb_linear_array_deque.sv
// Self-checking bench for linear_array_deque: a behavioural deque predicts each result beat,
// while both channels run under changing sender idle and receiver stall rates.
// Depends on ladq_pkg, ladq_in_if, ladq_out_if and the deque RTL.
module tb_linear_array_deque;
  timeunit 1ns;
  timeprecision 1ps;
  import ladq_pkg::*;

  localparam int DEPTH        = DEPTH_DEF;
  localparam int COUNT_W      = $clog2(DEPTH + 1);
  localparam int CYCLE_LIMIT  = 300000;  // far above the slowest legal run
  localparam int DRAIN_CYCLES = 16;      // extra wait after the last predicted beat is taken
  localparam int REPORT_MAX   = 10;

  // request codes 5..7 are unused and behave as a plain query
  localparam logic [REQ_W-1:0] REQ_RSVD_FIRST = 3'd5;
  localparam logic [REQ_W-1:0] REQ_RSVD_LAST  = 3'd7;

  localparam logic signed [DATA_W-1:0] EMPTY_VALUE = -1;
  localparam logic signed [DATA_W-1:0] DATA_MIN    = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] DATA_MAX    = 32'sh7fff_ffff;

  // one result beat as the deque should report it
  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic [COUNT_W-1:0]       count;
    logic signed [DATA_W-1:0] front_value;
    logic signed [DATA_W-1:0] back_value;
  } deque_view_t;

  logic clk;
  logic rst_n;

  ladq_in_if                      in_if();
  ladq_out_if #(.COUNT_W(COUNT_W)) out_if();

  linear_array_deque #(.DEPTH(DEPTH)) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  // shadow deque: same linear store, head/tail indices and empty flag
  logic signed [DATA_W-1:0] shadow_slots [DEPTH];
  int                       head_idx;
  int                       tail_idx;
  bit                       deque_empty;

  deque_view_t expected_views[$];   // predicted beats, oldest first

  int send_idle_pct;    // chance per cycle that the sender holds off
  int recv_stall_pct;   // chance per cycle that the receiver drops ready
  int mismatches;
  int items_sent;
  int cycle_count = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // watchdog: a hung handshake must not stall the run forever
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic int held_items();
    return deque_empty ? 0 : tail_idx - head_idx + 1;
  endfunction

  // Advance the shadow deque by one accepted request and queue the beat it yields.
  // Overflow and underflow leave the state untouched.
  function automatic void apply_request(input logic [REQ_W-1:0] code,
                                        input logic signed [DATA_W-1:0] value);
    deque_view_t view;
    view.status = ST_OK;
    case (code)
      REQ_PUSH_BACK, REQ_PUSH_FRONT: begin
        if (deque_empty) begin
          // either push into an empty deque lands in slot 0
          head_idx        = 0;
          tail_idx        = 0;
          shadow_slots[0] = value;
          deque_empty     = 1'b0;
        end else if (code == REQ_PUSH_BACK) begin
          if (tail_idx == DEPTH - 1) begin
            view.status = ST_OVERFLOW;
          end else begin
            tail_idx++;
            shadow_slots[tail_idx] = value;
          end
        end else if (head_idx == 0) begin
          // no wrap: slots freed at the back cannot be reached from the front
          view.status = ST_OVERFLOW;
        end else begin
          head_idx--;
          shadow_slots[head_idx] = value;
        end
      end
      REQ_POP_FRONT, REQ_POP_BACK: begin
        if (deque_empty) begin
          view.status = ST_UNDERFLOW;
        end else if (head_idx == tail_idx) begin
          // last item gone: back to the reset shape
          deque_empty = 1'b1;
          head_idx    = 0;
          tail_idx    = 0;
        end else if (code == REQ_POP_FRONT) begin
          head_idx++;
        end else begin
          tail_idx--;
        end
      end
      default: ;  // query and the unused codes change nothing
    endcase
    view.count       = COUNT_W'(held_items());
    view.front_value = deque_empty ? EMPTY_VALUE : shadow_slots[head_idx];
    view.back_value  = deque_empty ? EMPTY_VALUE : shadow_slots[tail_idx];
    expected_views = {expected_views, view};
  endfunction

  // Compare one taken result beat with the oldest prediction.
  function automatic void check_result();
    deque_view_t want;
    if (expected_views.size() == 0) begin
      mismatches++;
      if (mismatches <= REPORT_MAX)
        $display("%0t: unexpected result beat: status %0d count %0d front %0d back %0d",
                 $time, out_if.status, out_if.count, out_if.front_value, out_if.back_value);
      return;
    end
    want = expected_views[0];
    expected_views.delete(0);
    if (out_if.status !== want.status || out_if.count !== want.count ||
        out_if.front_value !== want.front_value || out_if.back_value !== want.back_value) begin
      mismatches++;
      if (mismatches <= REPORT_MAX)
        $display("%0t: result mismatch: expected status %0d count %0d front %0d back %0d, %s",
                 $time, want.status, want.count, want.front_value, want.back_value,
                 $sformatf("got status %0d count %0d front %0d back %0d", out_if.status,
                           out_if.count, out_if.front_value, out_if.back_value));
    end
  endfunction

  // Receiver: random back-pressure, and every taken beat is checked.
  // Both channels are sampled just after the edge, so they still hold pre-edge values.
  always @(posedge clk) begin
    out_if.ready <= rst_n && ($urandom_range(0, 99) >= recv_stall_pct);
    if (rst_n && out_if.valid && out_if.ready)
      check_result();
  end

  // Send one request beat. valid is left high after acceptance so that back-to-back
  // beats never lower and raise it within one step; idle cycles lower it instead.
  task automatic send_request(input logic [REQ_W-1:0] code,
                              input logic signed [DATA_W-1:0] value);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid    <= 1'b0;
      in_if.req_type <= REQ_W'($urandom);   // junk on an idle bus
      in_if.data     <= $urandom;
      @(posedge clk);
    end
    in_if.valid    <= 1'b1;
    in_if.req_type <= code;
    in_if.data     <= value;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    apply_request(code, value);
    items_sent++;
  endtask

  // data: mostly random, with the extremes and all-ones (looks like the empty marker)
  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 11))
      0:       return DATA_MIN;
      1:       return DATA_MAX;
      2:       return EMPTY_VALUE;
      3:       return '0;
      default: return $urandom;
    endcase
  endfunction

  // request mix leaning towards growth or towards shrinkage
  function automatic logic [REQ_W-1:0] pick_op(input bit filling);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < (filling ? 40 : 10)) return REQ_PUSH_BACK;
    if (roll < (filling ? 65 : 18)) return REQ_PUSH_FRONT;
    if (roll < (filling ? 78 : 50)) return REQ_POP_FRONT;
    if (roll < (filling ? 88 : 85)) return REQ_POP_BACK;
    if (roll < 95)                  return REQ_QUERY;
    return REQ_W'($urandom_range(REQ_RSVD_FIRST, REQ_RSVD_LAST));
  endfunction

  // Grow then shrink: wanders through most index positions.
  task automatic walk_episode();
    int len;
    len = $urandom_range(8, 48);
    for (int i = 0; i < len; i++)
      send_request(pick_op(i < len / 2), pick_value());
  endtask

  // Drain, fill until a back push overflows, open a gap at the front, refill it until
  // a front push overflows, then drain past empty into underflow.
  task automatic capacity_episode();
    int gap;
    while (held_items() > 0)
      send_request($urandom_range(0, 1) ? REQ_POP_FRONT : REQ_POP_BACK, pick_value());
    for (int i = 0; i <= DEPTH; i++)
      send_request(REQ_PUSH_BACK, pick_value());
    gap = $urandom_range(1, DEPTH - 1);
    for (int i = 0; i < gap; i++)
      send_request(REQ_POP_FRONT, pick_value());
    for (int i = 0; i <= gap; i++)
      send_request(REQ_PUSH_FRONT, pick_value());
    while (held_items() > 0)
      send_request($urandom_range(0, 1) ? REQ_POP_FRONT : REQ_POP_BACK, pick_value());
    send_request($urandom_range(0, 1) ? REQ_POP_FRONT : REQ_POP_BACK, pick_value());
  endtask

  // any code, any data
  task automatic noise_episode();
    int len;
    len = $urandom_range(4, 12);
    for (int i = 0; i < len; i++)
      send_request(REQ_W'($urandom_range(0, 7)), pick_value());
  endtask

  // Empty-deque corner cases: query, underflow, push into empty from either end,
  // front overflow at slot 0, popping the only item, an unused code.
  task automatic test_empty_deque();
    send_request(REQ_QUERY, pick_value());
    send_request(REQ_POP_FRONT, pick_value());
    send_request(REQ_PUSH_FRONT, DATA_MAX);
    send_request(REQ_PUSH_FRONT, DATA_MIN);
    send_request(REQ_POP_BACK, pick_value());
    send_request(REQ_RSVD_FIRST, DATA_MAX);
    send_request(REQ_PUSH_BACK, DATA_MIN);
    send_request(REQ_POP_FRONT, pick_value());
  endtask

  // Fill the store from the back to all DEPTH slots, then overflow at the last slot.
  task automatic test_capacity();
    send_request(REQ_PUSH_BACK, EMPTY_VALUE);
    send_request(REQ_PUSH_BACK, '0);
    for (int i = 2; i < DEPTH; i++)
      send_request(REQ_PUSH_BACK, pick_value());
    send_request(REQ_PUSH_BACK, DATA_MAX);
  endtask

  // Random traffic phase. About one episode in four runs with no idling at all.
  task automatic test_random_traffic(input int n_items, input int idle_pct,
                                     input int stall_pct);
    int target;
    int kind;
    target = items_sent + n_items;
    while (items_sent < target) begin
      if ($urandom_range(0, 3) == 0) begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end else begin
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
      end
      kind = $urandom_range(0, 9);
      if (kind < 6)
        walk_episode();
      else if (kind < 9)
        capacity_episode();
      else
        noise_episode();
    end
  endtask

  initial begin
    in_if.valid    <= 1'b0;
    in_if.req_type <= REQ_QUERY;
    in_if.data     <= '0;
    rst_n          <= 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    mismatches     = 0;
    items_sent     = 0;
    head_idx       = 0;
    tail_idx       = 0;
    deque_empty    = 1'b1;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_deque();
    test_capacity();
    test_random_traffic(425, 0, 0);
    test_random_traffic(425, 70, 0);
    test_random_traffic(425, 0, 70);
    test_random_traffic(425, 21, 21);

    // last beat was accepted in this step, so valid has had no other update here
    in_if.valid <= 1'b0;
    recv_stall_pct = 0;
    while (expected_views.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
